// File: src/elapsed_timeout_timer_macros.svh
// assertion helpers for the timeout timer checker
`ifndef ELAPSED_TIMEOUT_TIMER_MACROS_SVH
`define ELAPSED_TIMEOUT_TIMER_MACROS_SVH

// same-cycle implication, checked outside reset
`define ETT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define ETT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/ett_pkg.sv
`default_nettype none

package ett_pkg;

    localparam int TIMER_W          = 32;
    localparam int MS_W             = 31;
    localparam int TPM_W            = 32;
    localparam int TICK_W           = 64;
    localparam int SAMPLE_WIDTH_DEF = 32;

    localparam int DIV_STEPS = TICK_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    localparam logic [MS_W-1:0]  MS_MAX          = {MS_W{1'b1}};
    localparam logic [TPM_W-1:0] TPM_RESET       = 32'd1000;
    localparam logic             HW_ASSIST_RESET = 1'b1;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] CFG_HW_ASSIST = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TICKS     = 1'd1;

    localparam logic OP_START = 1'b0;
    localparam logic OP_POLL  = 1'b1;

    typedef struct packed {
        logic              operation;
        logic [MS_W-1:0]   milliseconds;
        logic [TIMER_W-1:0] timer_sample;
    } ett_in_t;

    typedef struct packed {
        logic            expired;
        logic [MS_W-1:0] remaining_ms;
    } ett_out_t;

    typedef struct packed {
        logic load;
        logic exec;
        logic check;
        logic prep;
        logic step;
        logic out_load;
    } ett_cmd_t;

    typedef struct packed {
        logic is_poll;
        logic skip_div;
        logic div_last;
    } ett_sts_t;

endpackage

`default_nettype wire

// File: src/ett_ctrl.sv
`default_nettype none

module ett_ctrl
    import ett_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_ready,
    output logic          out_valid,
    input  wire logic     out_ready,
    input  wire ett_sts_t sts,
    output ett_cmd_t      cmd
);

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_EXEC   = 6'b000010,
        ST_CHECK  = 6'b000100,
        ST_PREP   = 6'b001000,
        ST_DIV    = 6'b010000,
        ST_FINISH = 6'b100000
    } ett_state_t;

    ett_state_t state_reg, state_next;
    logic       out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = sts.is_poll ? ST_CHECK : ST_PREP;
            end
            ST_CHECK:
            begin
                cmd.check  = 1'b1;
                state_next = ST_PREP;
            end
            ST_PREP:
            begin
                cmd.prep   = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (sts.skip_div)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    cmd.step = 1'b1;
                    if (sts.div_last)
                    begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_FINISH:
            begin
                // wait for the output register to free up
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

// File: src/ett_datapath.sv
`default_nettype none

module ett_datapath
    import ett_pkg::*;
#(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire ett_in_t               in_data,
    output ett_out_t                   out_data,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire ett_cmd_t              cmd,
    output ett_sts_t                   sts
);

    localparam int SampleInW = (SAMPLE_WIDTH < TIMER_W) ? SAMPLE_WIDTH : TIMER_W;

    logic                    hw_assist_reg;
    logic [TPM_W-1:0]        tpm_reg;
    logic                    op_reg;
    logic [MS_W-1:0]         ms_reg;
    logic [SAMPLE_WIDTH-1:0] sample_reg;
    logic [TICK_W-1:0]       target_reg, target_next;
    logic [TICK_W-1:0]       elapsed_reg, elapsed_next;
    logic [SAMPLE_WIDTH-1:0] last_reg, last_next;
    logic                    expired_reg, expired_next;
    logic [TICK_W-1:0]       total_reg;
    logic [SAMPLE_WIDTH-1:0] now_reg;
    logic                    zero_reg;
    logic [TICK_W-1:0]       quo_reg, quo_next;
    logic [TPM_W-1:0]        rem_reg, rem_next;
    logic [DIV_CNT_W-1:0]    cnt_reg, cnt_next;
    ett_out_t                result_reg;

    logic [MS_W+TPM_W-1:0]   prod;
    logic [SAMPLE_WIDTH-1:0] now_val;
    logic [SAMPLE_WIDTH-1:0] delta;
    logic [TICK_W:0]         left_ext;
    logic [TPM_W:0]          trial;
    logic [TPM_W:0]          diff;
    logic                    trial_ge;

    assign prod    = (MS_W+TPM_W)'(ms_reg) * (MS_W+TPM_W)'(tpm_reg);
    assign now_val = hw_assist_reg ? sample_reg : last_reg + SAMPLE_WIDTH'(1);
    assign delta   = now_val - last_reg;

    // borrow out of the top bit means elapsed already passed the target
    assign left_ext = {1'b0, target_reg} - {1'b0, elapsed_reg};

    // one restoring division step
    assign trial    = {rem_reg, quo_reg[TICK_W-1]};
    assign diff     = trial - {1'b0, tpm_reg};
    assign trial_ge = trial >= {1'b0, tpm_reg};

    always_comb
    begin
        target_next  = target_reg;
        elapsed_next = elapsed_reg;
        last_next    = last_reg;
        expired_next = expired_reg;
        if (cmd.exec && op_reg == OP_START)
        begin
            target_next  = TICK_W'(prod);
            elapsed_next = '0;
            last_next    = hw_assist_reg ? sample_reg : '0;
            expired_next = 1'b0;
        end
        else if (cmd.check && !expired_reg)
        begin
            if (total_reg >= target_reg)
            begin
                expired_next = 1'b1;
            end
            else
            begin
                elapsed_next = total_reg;
                last_next    = now_reg;
            end
        end
    end

    always_comb
    begin
        quo_next = quo_reg;
        rem_next = rem_reg;
        cnt_next = cnt_reg;
        if (cmd.prep)
        begin
            quo_next = left_ext[TICK_W-1:0];
            rem_next = '0;
            cnt_next = '0;
        end
        else if (cmd.step)
        begin
            quo_next = {quo_reg[TICK_W-2:0], trial_ge};
            rem_next = trial_ge ? diff[TPM_W-1:0] : trial[TPM_W-1:0];
            cnt_next = cnt_reg + DIV_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hw_assist_reg <= HW_ASSIST_RESET;
            tpm_reg       <= TPM_RESET;
            target_reg    <= '0;
            elapsed_reg   <= '0;
            last_reg      <= '0;
            expired_reg   <= 1'b1;
            zero_reg      <= 1'b1;
            cnt_reg       <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_HW_ASSIST: hw_assist_reg <= cfg_data[0];
                    CFG_TICKS:     tpm_reg       <= cfg_data[TPM_W-1:0];
                    default:       tpm_reg       <= tpm_reg;
                endcase
            end
            target_reg  <= target_next;
            elapsed_reg <= elapsed_next;
            last_reg    <= last_next;
            expired_reg <= expired_next;
            cnt_reg     <= cnt_next;
            if (cmd.prep)
            begin
                zero_reg <= expired_reg || (tpm_reg == '0) || left_ext[TICK_W];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg     <= in_data.operation;
            ms_reg     <= in_data.milliseconds;
            sample_reg <= SAMPLE_WIDTH'(in_data.timer_sample[SampleInW-1:0]);
        end
        if (cmd.exec)
        begin
            total_reg <= elapsed_reg + TICK_W'(delta);
            now_reg   <= now_val;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        if (cmd.out_load)
        begin
            result_reg.expired <= expired_reg;
            if (zero_reg)
            begin
                result_reg.remaining_ms <= '0;
            end
            else if (quo_reg[TICK_W-1:MS_W] != '0)
            begin
                result_reg.remaining_ms <= MS_MAX;
            end
            else
            begin
                result_reg.remaining_ms <= quo_reg[MS_W-1:0];
            end
        end
    end

    assign sts.is_poll  = (op_reg == OP_POLL);
    assign sts.skip_div = zero_reg;
    assign sts.div_last = (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1));
    assign out_data     = result_reg;

endmodule

`default_nettype wire

// File: src/elapsed_timeout_timer.sv
// Millisecond timeout timer with a 64-bit elapsed tick total.
// Input channel (in_valid/in_ready, in_data): a start beat arms a timeout of
// milliseconds times tick_rate ticks; a poll beat adds the wrapped timer
// difference (or one tick in software mode) to the elapsed total.
// Output channel (out_valid/out_ready, out_data): one beat per input beat,
// carrying the sticky expired flag and the whole milliseconds left.
// Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data) is always ready;
// index 0 is hw_assist, index 1 is tick_rate. Write it only while idle.
// An input beat passes through the states EXEC, CHECK (polls only), PREP,
// DIV and FINISH before the output register is loaded; DIV runs the 64-step
// restoring divider for remaining time, or is skipped when the answer is
// known to be zero. One item is in flight at a time, so no input beat is
// taken until FINISH has handed the previous result to the output register.
// A new input beat is taken while the previous result still waits in the
// output register; a stalled receiver holds the result and the next result
// waits in the controller until the register frees up.
// Reset disarms the timer: expired reads 1, hw_assist 1, tick_rate 1000.
`default_nettype none

module elapsed_timeout_timer
    import ett_pkg::*;
#(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire ett_in_t               in_data,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output ett_out_t                   out_data,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    ett_cmd_t cmd;
    ett_sts_t sts;

    assign cfg_ready = 1'b1;

    ett_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    ett_datapath #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .out_data  (out_data),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

`default_nettype wire

// File: src/ett_checker.sv
`default_nettype none

`include "elapsed_timeout_timer_macros.svh"

module ett_checker
    import ett_pkg::*;
(
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  in_valid,
    input wire logic                  in_ready,
    input wire ett_in_t               in_data,
    input wire logic                  out_valid,
    input wire logic                  out_ready,
    input wire ett_out_t              out_data,
    input wire logic                  cfg_valid,
    input wire logic                  cfg_ready,
    input wire logic [CFG_IDX_W-1:0]  cfg_index,
    input wire logic [CFG_DATA_W-1:0] cfg_data
);

    // stalled result holds
    `ETT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "result changed while stalled")

    // one item at a time: busy right after an input beat
    `ETT_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "input taken while busy")

    // an expired timer has no time left
    `ETT_ASSERT_NOW(a_expired_zero, out_valid && out_data.expired, out_data.remaining_ms == '0, "expired with time left")

endmodule

bind elapsed_timeout_timer ett_checker u_ett_checker (.*);

`default_nettype wire

// File: tb/sv/ett_timeout_checker.sv
`timescale 1ns / 1ps

module ett_timeout_checker
    import ett_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_ready,
    input  ett_in_t               in_data,
    input  logic                  out_valid,
    input  logic                  out_ready,
    input  ett_out_t              out_data,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    pending,
    output int                    errors
);

    logic               hw_mode;
    logic [TPM_W-1:0]   rate;
    logic [TICK_W-1:0]  target_ticks;
    logic [TICK_W-1:0]  elapsed_ticks;
    logic [TIMER_W-1:0] last_sample;
    logic               expired_flag;
    ett_out_t           expected_status_q[$];
    ett_out_t           want;

    function automatic logic [MS_W-1:0] whole_ms_left();
        logic [TICK_W-1:0] quot;
        if (expired_flag || rate == '0 || elapsed_ticks >= target_ticks)
            return '0;
        quot = (target_ticks - elapsed_ticks) / TICK_W'(rate);
        return (quot > TICK_W'(MS_MAX)) ? MS_MAX : quot[MS_W-1:0];
    endfunction

    function automatic ett_out_t advance_timeout(input ett_in_t beat);
        logic [TIMER_W-1:0] now_sample;
        logic [TIMER_W-1:0] delta;
        logic [TICK_W-1:0]  total;
        ett_out_t           status;
        if (beat.operation == OP_START)
        begin
            target_ticks  = TICK_W'(beat.milliseconds) * TICK_W'(rate);
            elapsed_ticks = '0;
            last_sample   = hw_mode ? beat.timer_sample : '0;
            expired_flag  = 1'b0;
        end
        else if (!expired_flag)
        begin
            // software mode: each poll is worth exactly one tick
            now_sample = hw_mode ? beat.timer_sample : last_sample + 1'b1;
            delta      = now_sample - last_sample;
            total      = elapsed_ticks + TICK_W'(delta);
            if (total >= target_ticks)
                expired_flag = 1'b1;
            else
            begin
                last_sample   = now_sample;
                elapsed_ticks = total;
            end
        end
        status.expired      = expired_flag;
        status.remaining_ms = whole_ms_left();
        return status;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hw_mode       = HW_ASSIST_RESET;
            rate          = TPM_RESET;
            target_ticks  = '0;
            elapsed_ticks = '0;
            last_sample   = '0;
            expired_flag  = 1'b1;
            expected_status_q.delete();
            errors        = 0;
            pending      <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_HW_ASSIST: hw_mode = cfg_data[0];
                    CFG_TICKS:     rate    = cfg_data[TPM_W-1:0];
                    default:       ;
                endcase
            end
            if (out_valid && out_ready)
            begin
                if (expected_status_q.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("checker: result beat with nothing expected: expired=%0b remaining_ms=%0d",
                                 out_data.expired, out_data.remaining_ms);
                end
                else
                begin
                    want = expected_status_q.pop_front();
                    if (out_data.expired !== want.expired ||
                        out_data.remaining_ms !== want.remaining_ms)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("checker: mismatch: expired exp %0b got %0b, remaining_ms exp %0d got %0d",
                                     want.expired, out_data.expired,
                                     want.remaining_ms, out_data.remaining_ms);
                    end
                end
            end
            if (in_valid && in_ready)
                expected_status_q.push_back(advance_timeout(in_data));
            pending <= expected_status_q.size();
        end
    end

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
    import ett_pkg::*;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int RANDOM_ITEMS = 1950;
    localparam int PHASES       = 8;
    localparam int SETTLE       = 80;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    ett_in_t               in_data   = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    ett_out_t              out_data;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    int pending;
    int errors;
    int cycles         = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    elapsed_timeout_timer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    ett_timeout_checker status_check (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pending   (pending),
        .errors    (errors)
    );

    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= recv_stall_pct);

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("tb: FAIL");
            $finish;
        end
    end

    task automatic set_idling(input idle_mode_t mode);
        send_idle_pct  = (mode == IDLE_SENDER) ? 79 : (mode == IDLE_BOTH) ? 7 : 0;
        recv_stall_pct = (mode == IDLE_RECEIVER) ? 79 : (mode == IDLE_BOTH) ? 7 : 0;
    endtask

    task automatic push_item(input logic op, input logic [MS_W-1:0] ms,
                             input logic [TIMER_W-1:0] sample);
        ett_in_t beat;
        beat.operation    = op;
        beat.milliseconds = ms;
        beat.timer_sample = sample;
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle_pct)
                @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= beat;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // hold off the sender until every result is back, then let the divider settle
    task automatic wait_until_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic configure(input logic hw, input logic [TPM_W-1:0] rate);
        wait_until_idle();
        cfg_valid <= 1'b1;
        cfg_index <= CFG_HW_ASSIST;
        cfg_data  <= CFG_DATA_W'(hw);
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_index <= CFG_TICKS;
        cfg_data  <= rate;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    // start beats followed by runs of polls whose sample steps are near the
    // tick rate, so timeouts count down and expire; a tenth is random noise
    task automatic run_phase(input idle_mode_t mode, input logic hw,
                             input logic [TPM_W-1:0] rate, input int count);
        int                 done;
        int                 polls;
        logic [TIMER_W-1:0] stamp;
        logic [TIMER_W-1:0] step;
        logic [MS_W-1:0]    span;
        done = 0;
        configure(hw, rate);
        set_idling(mode);
        while (done < count)
        begin
            if ($urandom_range(9) == 0)
            begin
                push_item(1'($urandom_range(1)), MS_W'($urandom), $urandom);
                done++;
            end
            else
            begin
                case ($urandom_range(9))
                    0:       span = '0;
                    1:       span = MS_W'($urandom);
                    default: span = MS_W'($urandom_range(1, 12));
                endcase
                stamp = $urandom;
                push_item(OP_START, span, stamp);
                done++;
                polls = $urandom_range(1, 24);
                repeat (polls)
                begin
                    case ($urandom_range(7))
                        0:       step = $urandom;
                        1:       step = '0;
                        default: step = (rate > 32'h7fff_ffff) ? $urandom
                                                               : $urandom_range(0, 2 * rate);
                    endcase
                    stamp = stamp + step;
                    push_item(OP_POLL, MS_W'($urandom), stamp);
                    done++;
                end
            end
        end
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // poll straight out of reset reads as expired
        push_item(OP_POLL, MS_MAX, 32'hffff_ffff);
        // zero-length timeout expires on its first poll
        push_item(OP_START, '0, 32'd5);
        push_item(OP_POLL, '0, 32'd5);
        // longest timeout, sample wraps through zero
        push_item(OP_START, MS_MAX, 32'hffff_fff0);
        push_item(OP_POLL, '0, 32'h0000_0010);
        push_item(OP_POLL, MS_MAX, 32'hffff_ffff);
        // rate lowered after the start: remaining time saturates
        configure(1'b1, 32'd1);
        push_item(OP_POLL, '0, 32'h0000_0000);
        // largest rate, full-range deltas land exactly on the target
        configure(1'b1, 32'hffff_ffff);
        push_item(OP_START, 31'd3, '0);
        push_item(OP_POLL, '0, 32'hffff_ffff);
        push_item(OP_POLL, '0, 32'hffff_fffe);
        push_item(OP_POLL, '0, 32'hffff_fffd);
        push_item(OP_POLL, '0, 32'h0000_0000);
        // software mode: six polls to expire, then one more on a sticky flag
        configure(1'b0, 32'd3);
        push_item(OP_START, 31'd2, $urandom);
        repeat (7) push_item(OP_POLL, MS_W'($urandom), $urandom);
        // zero rate gives a zero target
        configure(1'b0, 32'd0);
        push_item(OP_START, 31'd100, $urandom);
        push_item(OP_POLL, '0, $urandom);

        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0:       run_phase(IDLE_NONE,     1'b1, 32'd1000,      RANDOM_ITEMS / PHASES);
                1:       run_phase(IDLE_SENDER,   1'b0, 32'd3,         RANDOM_ITEMS / PHASES);
                2:       run_phase(IDLE_RECEIVER, 1'b1, 32'd1,         RANDOM_ITEMS / PHASES);
                3:       run_phase(IDLE_BOTH,     1'b0, 32'd1,         RANDOM_ITEMS / PHASES);
                4:       run_phase(IDLE_NONE,     1'b1, 32'hffff_ffff, RANDOM_ITEMS / PHASES);
                5:       run_phase(IDLE_SENDER,   1'b0, 32'd2,         RANDOM_ITEMS / PHASES);
                6:       run_phase(IDLE_RECEIVER, 1'b1, $urandom,      RANDOM_ITEMS / PHASES);
                default: run_phase(IDLE_BOTH,     1'b1, $urandom_range(2, 64),
                                   RANDOM_ITEMS / PHASES);
            endcase
        end

        wait_until_idle();
        if (errors == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule
